/* hdl/bcd_pkg.sv */
`default_nettype none

package bcd_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_WINDOW    = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_index_t;

    localparam logic [7:0]  DEBOUNCE_RESET  = 8'd10;
    localparam logic [15:0] WINDOW_RESET    = 16'd200;
    localparam logic [15:0] THRESHOLD_RESET = 16'd600;

    localparam logic [15:0] HOLD_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SINGLE = 2'd1,
        ACT_DOUBLE = 2'd2,
        ACT_LONG   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PRESS  = 2'd1,
        PH_WAIT   = 2'd2,
        PH_SECOND = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  debounce;
        logic [15:0] window;
        logic [15:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic step;
        logic clear;
    } lane_ctrl_t;

endpackage

`default_nettype wire

/* hdl/bcd_lane.sv */
`default_nettype none

module bcd_lane
    import bcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lane_ctrl_t ctrl,
    input  wire logic       raw,
    input  wire cfg_t       cfg,
    output action_t         action_next
);

    logic        level_reg, level_next;
    logic [7:0]  count_reg, count_next;
    phase_t      phase_reg, phase_next;
    logic        long_reg, long_next;
    logic [15:0] hold_reg, hold_next;
    logic [15:0] window_reg, window_next;
    action_t     latch_reg;

    logic        deb_level;
    logic [7:0]  deb_count;
    logic [7:0]  count_inc;
    logic        press_edge;
    logic        release_edge;
    phase_t      phase_mid;
    logic        long_mid;
    logic [15:0] hold_mid;
    logic [15:0] window_mid;
    logic [15:0] hold_tick;
    logic [15:0] window_tick;
    logic        post_long;
    logic        post_single;
    logic        post_double;

    // debounce
    always_comb
    begin
        count_inc = count_reg + 8'd1;
        deb_level = level_reg;
        deb_count = 8'd0;
        if (raw != level_reg)
        begin
            if (count_inc >= cfg.debounce)
            begin
                deb_level = raw;
            end
            else
            begin
                deb_count = count_inc;
            end
        end
        press_edge   = (deb_level != level_reg) && deb_level;
        release_edge = (deb_level != level_reg) && !deb_level;
    end

    // phase change on debounced edges
    always_comb
    begin
        phase_mid = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (press_edge)
                begin
                    phase_mid = PH_PRESS;
                end
            end
            PH_PRESS:
            begin
                if (release_edge)
                begin
                    phase_mid = long_reg ? PH_IDLE : PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (press_edge)
                begin
                    phase_mid = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (release_edge)
                begin
                    phase_mid = PH_IDLE;
                end
            end
            default:
            begin
                phase_mid = PH_IDLE;
            end
        endcase
    end

    // next state: window expiry ends the wait
    always_comb
    begin
        phase_next = phase_reg;
        if (ctrl.step)
        begin
            phase_next = post_single ? PH_IDLE : phase_mid;
        end
    end

    // counters and reports
    always_comb
    begin
        post_double = (phase_reg == PH_WAIT) && press_edge;

        long_mid   = (phase_reg == PH_IDLE && press_edge) ? 1'b0 : long_reg;
        hold_mid   = (phase_reg == PH_IDLE && press_edge) ? 16'd0 : hold_reg;
        window_mid = (phase_reg == PH_PRESS && release_edge && !long_reg)
                     ? cfg.window : window_reg;

        hold_tick   = (hold_mid == HOLD_MAX) ? hold_mid : hold_mid + 16'd1;
        window_tick = (window_mid != 16'd0) ? window_mid - 16'd1 : window_mid;

        post_long   = (phase_mid == PH_PRESS) && (hold_tick >= cfg.threshold) && !long_mid;
        post_single = (phase_mid == PH_WAIT) && (window_tick == 16'd0);

        level_next  = level_reg;
        count_next  = count_reg;
        long_next   = long_reg;
        hold_next   = hold_reg;
        window_next = window_reg;
        if (ctrl.step)
        begin
            level_next  = deb_level;
            count_next  = deb_count;
            long_next   = long_mid | post_long;
            hold_next   = (phase_mid == PH_PRESS) ? hold_tick : hold_mid;
            window_next = (phase_mid == PH_WAIT) ? window_tick : window_mid;
        end

        action_next = latch_reg;
        if (ctrl.clear)
        begin
            action_next = ACT_NONE;
        end
        else if (ctrl.step && latch_reg == ACT_NONE)
        begin
            if (post_double)
            begin
                action_next = ACT_DOUBLE;
            end
            else if (post_long)
            begin
                action_next = ACT_LONG;
            end
            else if (post_single)
            begin
                action_next = ACT_SINGLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= 1'b0;
            count_reg  <= 8'd0;
            phase_reg  <= PH_IDLE;
            long_reg   <= 1'b0;
            hold_reg   <= 16'd0;
            window_reg <= 16'd0;
            latch_reg  <= ACT_NONE;
        end
        else
        begin
            level_reg  <= level_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            long_reg   <= long_next;
            hold_reg   <= hold_next;
            window_reg <= window_next;
            latch_reg  <= action_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/button_click_double_long_detector_top.sv */
// Two-key click detector. Each request on the s_ stream is either a tick (s_tuser = 0),
// which debounces both raw key levels and advances each key's gesture machine, or a
// clear (s_tuser = 1), which empties both action latches. Every request yields exactly
// one result on the m_ stream carrying both latches (0 none, 1 single, 2 double,
// 3 long). The block takes one request per clock. A request is held in the input
// register; the lanes then fill the result register, from which the result is offered.
// Backpressure on m_tready stalls both stages. Debounce count, double-click window and
// long-press threshold reset to 10, 200 and 600 ticks and sit at APB byte addresses
// 0x0, 0x4 and 0x8; write them only while no request is in flight.
`default_nettype none

module button_click_double_long_detector_top
    import bcd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [0] raw_key_one, [1] raw_key_two, [7:2] zero
    input  wire logic                  s_tuser,   // [0] op

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [1:0] action_key_one, [3:2] action_key_two

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    cfg_t        cfg_reg;
    logic        cfg_write;
    reg_index_t  cfg_index;

    logic        in_valid_reg;
    logic        op_reg;
    logic        raw_one_reg;
    logic        raw_two_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;

    logic        advance;
    logic        accept;
    lane_ctrl_t  lane_ctrl;
    action_t     action_one;
    action_t     action_two;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[CFG_ADDR_W-1:2]);

    always_comb
    begin
        case (cfg_index)
            REG_DEBOUNCE:  prdata = {24'd0, cfg_reg.debounce};
            REG_WINDOW:    prdata = {16'd0, cfg_reg.window};
            REG_THRESHOLD: prdata = {16'd0, cfg_reg.threshold};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce  <= DEBOUNCE_RESET;
            cfg_reg.window    <= WINDOW_RESET;
            cfg_reg.threshold <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEBOUNCE:  cfg_reg.debounce  <= pwdata[7:0];
                REG_WINDOW:    cfg_reg.window    <= pwdata[15:0];
                REG_THRESHOLD: cfg_reg.threshold <= pwdata[15:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // two-stage pipe: input register, then lanes into the result register
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign accept    = s_tvalid && s_tready;
    assign lane_ctrl = '{step: advance && !op_reg, clear: advance && op_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= s_tuser;
            raw_one_reg <= s_tdata[0];
            raw_two_reg <= s_tdata[1];
        end
        if (advance)
        begin
            out_data_reg <= {4'd0, action_two, action_one};
        end
    end

    bcd_lane u_lane_one (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (lane_ctrl),
        .raw         (raw_one_reg),
        .cfg         (cfg_reg),
        .action_next (action_one)
    );

    bcd_lane u_lane_two (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (lane_ctrl),
        .raw         (raw_two_reg),
        .cfg         (cfg_reg),
        .action_next (action_two)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/bcd_checker.sv */
`default_nettype none

module bcd_checker
    import bcd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [7:0]            m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    input  wire logic [CFG_DATA_W-1:0] prdata,
    input  wire logic                  pready
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty output side never blocks a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request blocked with output empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:4] == 4'd0)
        else $error("result padding not zero");

    // written debounce count reads back
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_DEBOUNCE)
        ##1 (paddr[CFG_ADDR_W-1:2] == REG_DEBOUNCE)
        |-> prdata == {24'd0, $past(pwdata[7:0])})
        else $error("debounce register readback mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid || s_tready)
        else $error("output drained but input still blocked");

endmodule

bind button_click_double_long_detector_top bcd_checker u_bcd_checker (.*);

`default_nettype wire
